// ----- src/pti_pkg.sv -----
// Shared types, widths and the restoring-division step for the periodic track interpolator.
// No dependencies; used by periodic_track_interpolator_core.
package pti_pkg;

    localparam int TW = 62;   // time and register width
    localparam int CW = 63;   // coordinate width
    localparam int OW = 64;   // result width
    localparam int QB = 64;   // quotient bits per division, one per stage

    typedef enum logic [1:0] {
        REG_PERIOD       = 2'd0,
        REG_STEP_TIME    = 2'd1,
        REG_CLOCK_OFFSET = 2'd2
    } cfg_reg_t;

    // On a load, a_x/a_y carry the point; on a query they carry the base position.
    typedef struct packed {
        logic          is_load;
        logic [5:0]    idx;
        logic [CW-1:0] a_x;
        logic [CW-1:0] a_y;
    } item_t;

    // Partial remainder and the dividend shifter that collects quotient bits.
    typedef struct packed {
        logic [TW-1:0] rem;
        logic [QB-1:0] quo;
    } dstep_t;

    typedef struct packed {
        logic [CW-1:0] bx;
        logic [CW-1:0] by;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic          negx;
        logic          negy;
    } tail_t;

    // One restoring-division step. The partial remainder stays below the divisor.
    function automatic dstep_t div_step(input dstep_t s, input logic [TW-1:0] dvs);
        logic [TW:0] trial;
        dstep_t      o;
        trial = {s.rem, s.quo[QB-1]};
        o.quo = {s.quo[QB-2:0], 1'b0};
        if (trial >= {1'b0, dvs}) begin
            o.rem    = TW'(trial - {1'b0, dvs});
            o.quo[0] = 1'b1;
        end else begin
            o.rem = trial[TW-1:0];
        end
        return o;
    endfunction

endpackage

// ----- src/periodic_track_interpolator_core.sv -----
// Each query word gives one result word; loads give none. One word is taken per cycle
// while the skid entry is free. The depth comes from three bit-serial dividers of
// 64 stages each (time modulo period, segment and remainder, scaled difference).
// A two-entry output register with skid buffer keeps s_ready registered.
// Reset (aresetn, synchronous, active low) clears all valid bits and sets period and
// step_time to 1 and clock_offset to 0; the point table is not cleared.
module periodic_track_interpolator_core #(
    parameter int POINTS = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  logic [pti_pkg::TW-1:0]     s_query_time,
    input  logic [5:0]                 s_point_index,
    input  logic signed [pti_pkg::CW-1:0] s_point_x,
    input  logic signed [pti_pkg::CW-1:0] s_point_y,
    input  logic signed [pti_pkg::CW-1:0] s_base_x,
    input  logic signed [pti_pkg::CW-1:0] s_base_y,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [pti_pkg::OW-1:0] m_pos_x,
    output logic signed [pti_pkg::OW-1:0] m_pos_y,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [pti_pkg::TW-1:0]     cfg_data
);
    import pti_pkg::*;

    localparam int AW = $clog2(POINTS);

    logic          adv;
    logic [TW-1:0] per_reg, stp_reg, cof_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            per_reg <= TW'(1);
            stp_reg <= TW'(1);
            cof_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PERIOD:       per_reg <= (cfg_data == '0) ? TW'(1) : cfg_data;
                REG_STEP_TIME:    stp_reg <= (cfg_data == '0) ? TW'(1) : cfg_data;
                REG_CLOCK_OFFSET: cof_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- entry stage ----------------
    logic          e_v_reg;
    item_t         e_it_reg;
    logic [TW:0]   e_sum_reg;

    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) e_v_reg <= 1'b0;
        else if (adv) e_v_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_it_reg.is_load <= s_cmd;
            e_it_reg.idx     <= s_point_index;
            e_it_reg.a_x     <= s_cmd ? s_point_x : s_base_x;
            e_it_reg.a_y     <= s_cmd ? s_point_y : s_base_y;
            e_sum_reg        <= {1'b0, s_query_time} + {1'b0, cof_reg};
        end
    end

    // ---------------- time modulo period ----------------
    logic   m_v_reg  [QB];
    item_t  m_it_reg [QB];
    dstep_t m_s_reg  [QB];
    logic   m_v_src  [QB];
    item_t  m_it_src [QB];
    dstep_t m_s_src  [QB];

    for (genvar k = 0; k < QB; k++) begin : g_mod
        if (k == 0) begin : g_first
            assign m_v_src[k]  = e_v_reg;
            assign m_it_src[k] = e_it_reg;
            assign m_s_src[k]  = '{rem: '0, quo: {1'b0, e_sum_reg}};
        end else begin : g_rest
            assign m_v_src[k]  = m_v_reg[k-1];
            assign m_it_src[k] = m_it_reg[k-1];
            assign m_s_src[k]  = m_s_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) m_v_reg[k] <= 1'b0;
            else if (adv) m_v_reg[k] <= m_v_src[k];
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                m_it_reg[k] <= m_it_src[k];
                m_s_reg[k]  <= div_step(m_s_src[k], per_reg);
            end
        end
    end

    // ---------------- segment and remainder ----------------
    logic   d_v_reg  [QB];
    item_t  d_it_reg [QB];
    dstep_t d_s_reg  [QB];
    logic   d_v_src  [QB];
    item_t  d_it_src [QB];
    dstep_t d_s_src  [QB];

    for (genvar k = 0; k < QB; k++) begin : g_seg
        if (k == 0) begin : g_first
            assign d_v_src[k]  = m_v_reg[QB-1];
            assign d_it_src[k] = m_it_reg[QB-1];
            assign d_s_src[k]  = '{rem: '0, quo: {2'b00, m_s_reg[QB-1].rem}};
        end else begin : g_rest
            assign d_v_src[k]  = d_v_reg[k-1];
            assign d_it_src[k] = d_it_reg[k-1];
            assign d_s_src[k]  = d_s_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) d_v_reg[k] <= 1'b0;
            else if (adv) d_v_reg[k] <= d_v_src[k];
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                d_it_reg[k] <= d_it_src[k];
                d_s_reg[k]  <= div_step(d_s_src[k], stp_reg);
            end
        end
    end

    // ---------------- clamp and next point ----------------
    logic          c_v_reg;
    item_t         c_it_reg;
    logic [AW-1:0] c_seg_reg, c_nxt_reg, seg_next;
    logic [TW-1:0] c_rem_reg;

    always_comb begin
        if (d_s_reg[QB-1].quo > QB'(POINTS - 1)) seg_next = AW'(POINTS - 1);
        else                                    seg_next = d_s_reg[QB-1].quo[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) c_v_reg <= 1'b0;
        else if (adv) c_v_reg <= d_v_reg[QB-1];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_it_reg  <= d_it_reg[QB-1];
            c_seg_reg <= seg_next;
            c_nxt_reg <= (seg_next == AW'(POINTS - 1)) ? '0 : seg_next + AW'(1);
            c_rem_reg <= d_s_reg[QB-1].rem;
        end
    end

    // ---------------- point table ----------------
    // Loads travel down the pipeline and write here, so a query sees exactly the
    // loads that were accepted before it.
    logic [CW-1:0] mem_x [POINTS];
    logic [CW-1:0] mem_y [POINTS];
    logic          c_wr;
    logic [AW-1:0] waddr;

    assign c_wr  = c_v_reg && c_it_reg.is_load && (32'(c_it_reg.idx) < 32'(POINTS));
    assign waddr = AW'(c_it_reg.idx);

    logic          r_v_reg;
    logic [CW-1:0] r_bx_reg, r_by_reg, r_sx_reg, r_nx_reg, r_sy_reg, r_ny_reg;
    logic [TW-1:0] r_rem_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (c_wr) begin
                mem_x[waddr] <= c_it_reg.a_x;
                mem_y[waddr] <= c_it_reg.a_y;
            end
            r_sx_reg <= mem_x[c_seg_reg];
            r_nx_reg <= mem_x[c_nxt_reg];
            r_sy_reg <= mem_y[c_seg_reg];
            r_ny_reg <= mem_y[c_nxt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) r_v_reg <= 1'b0;
        else if (adv) r_v_reg <= c_v_reg && !c_it_reg.is_load;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_bx_reg  <= c_it_reg.a_x;
            r_by_reg  <= c_it_reg.a_y;
            r_rem_reg <= c_rem_reg;
        end
    end

    // ---------------- difference and magnitude ----------------
    logic          f_v_reg;
    tail_t         f_tail_reg;
    logic [OW-1:0] f_magx_reg, f_magy_reg, diffx_next, diffy_next;
    logic [TW-1:0] f_rem_reg;

    assign diffx_next = {r_nx_reg[CW-1], r_nx_reg} - {r_sx_reg[CW-1], r_sx_reg};
    assign diffy_next = {r_ny_reg[CW-1], r_ny_reg} - {r_sy_reg[CW-1], r_sy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) f_v_reg <= 1'b0;
        else if (adv) f_v_reg <= r_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_tail_reg.bx   <= r_bx_reg;
            f_tail_reg.by   <= r_by_reg;
            f_tail_reg.sx   <= r_sx_reg;
            f_tail_reg.sy   <= r_sy_reg;
            f_tail_reg.negx <= diffx_next[OW-1];
            f_tail_reg.negy <= diffy_next[OW-1];
            f_magx_reg      <= diffx_next[OW-1] ? -diffx_next : diffx_next;
            f_magy_reg      <= diffy_next[OW-1] ? -diffy_next : diffy_next;
            f_rem_reg       <= r_rem_reg;
        end
    end

    // ---------------- partial products ----------------
    logic          p_v_reg;
    tail_t         p_tail_reg;
    logic [63:0]   p_x0_reg, p_x2_reg, p_y0_reg, p_y2_reg;
    logic [61:0]   p_x1_reg, p_x3_reg, p_y1_reg, p_y3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) p_v_reg <= 1'b0;
        else if (adv) p_v_reg <= f_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_tail_reg <= f_tail_reg;
            p_x0_reg   <= f_magx_reg[31:0]  * f_rem_reg[31:0];
            p_x1_reg   <= f_magx_reg[31:0]  * f_rem_reg[61:32];
            p_x2_reg   <= f_magx_reg[63:32] * f_rem_reg[31:0];
            p_x3_reg   <= f_magx_reg[63:32] * f_rem_reg[61:32];
            p_y0_reg   <= f_magy_reg[31:0]  * f_rem_reg[31:0];
            p_y1_reg   <= f_magy_reg[31:0]  * f_rem_reg[61:32];
            p_y2_reg   <= f_magy_reg[63:32] * f_rem_reg[31:0];
            p_y3_reg   <= f_magy_reg[63:32] * f_rem_reg[61:32];
        end
    end

    // ---------------- product sum ----------------
    localparam int PW = OW + TW;

    logic          q_v_reg;
    tail_t         q_tail_reg;
    dstep_t        q_sx_reg, q_sy_reg;
    logic [PW-1:0] prodx_next, prody_next;

    assign prodx_next = PW'(p_x0_reg) + (PW'(p_x1_reg) << 32) + (PW'(p_x2_reg) << 32)
                      + (PW'(p_x3_reg) << 64);
    assign prody_next = PW'(p_y0_reg) + (PW'(p_y1_reg) << 32) + (PW'(p_y2_reg) << 32)
                      + (PW'(p_y3_reg) << 64);

    always_ff @(posedge aclk) begin
        if (!aresetn) q_v_reg <= 1'b0;
        else if (adv) q_v_reg <= p_v_reg;
    end

    // The high half of the product is below the step time, so it seeds the remainder.
    always_ff @(posedge aclk) begin
        if (adv) begin
            q_tail_reg <= p_tail_reg;
            q_sx_reg   <= '{rem: prodx_next[PW-1:OW], quo: prodx_next[OW-1:0]};
            q_sy_reg   <= '{rem: prody_next[PW-1:OW], quo: prody_next[OW-1:0]};
        end
    end

    // ---------------- scaled difference division ----------------
    logic   w_v_reg    [QB];
    tail_t  w_tail_reg [QB];
    dstep_t w_sx_reg   [QB];
    dstep_t w_sy_reg   [QB];
    logic   w_v_src    [QB];
    tail_t  w_tail_src [QB];
    dstep_t w_sx_src   [QB];
    dstep_t w_sy_src   [QB];

    for (genvar k = 0; k < QB; k++) begin : g_scl
        if (k == 0) begin : g_first
            assign w_v_src[k]    = q_v_reg;
            assign w_tail_src[k] = q_tail_reg;
            assign w_sx_src[k]   = q_sx_reg;
            assign w_sy_src[k]   = q_sy_reg;
        end else begin : g_rest
            assign w_v_src[k]    = w_v_reg[k-1];
            assign w_tail_src[k] = w_tail_reg[k-1];
            assign w_sx_src[k]   = w_sx_reg[k-1];
            assign w_sy_src[k]   = w_sy_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) w_v_reg[k] <= 1'b0;
            else if (adv) w_v_reg[k] <= w_v_src[k];
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                w_tail_reg[k] <= w_tail_src[k];
                w_sx_reg[k]   <= div_step(w_sx_src[k], stp_reg);
                w_sy_reg[k]   <= div_step(w_sy_src[k], stp_reg);
            end
        end
    end

    // ---------------- final sum and output buffer ----------------
    tail_t         tl;
    logic [OW-1:0] qx, qy, posx_next, posy_next;
    logic          push;

    assign tl = w_tail_reg[QB-1];
    assign qx = w_sx_reg[QB-1].quo;
    assign qy = w_sy_reg[QB-1].quo;
    assign posx_next = (tl.negx ? -qx : qx) + {tl.sx[CW-1], tl.sx} + {tl.bx[CW-1], tl.bx};
    assign posy_next = (tl.negy ? -qy : qy) + {tl.sy[CW-1], tl.sy} + {tl.by[CW-1], tl.by};
    assign push = adv && w_v_reg[QB-1];

    logic          o_v_reg, sk_v_reg;
    logic [OW-1:0] o_x_reg, o_y_reg, sk_x_reg, sk_y_reg;

    // The pipeline moves only while the skid entry is free.
    assign adv = !sk_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_v_reg  <= 1'b0;
            sk_v_reg <= 1'b0;
        end else if (!o_v_reg || m_ready) begin
            if (sk_v_reg) begin
                o_v_reg  <= 1'b1;
                sk_v_reg <= 1'b0;
            end else begin
                o_v_reg <= push;
            end
        end else if (push) begin
            sk_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!o_v_reg || m_ready) begin
            o_x_reg <= sk_v_reg ? sk_x_reg : posx_next;
            o_y_reg <= sk_v_reg ? sk_y_reg : posy_next;
        end else if (push) begin
            sk_x_reg <= posx_next;
            sk_y_reg <= posy_next;
        end
    end

    assign m_valid = o_v_reg;
    assign m_pos_x = o_x_reg;
    assign m_pos_y = o_y_reg;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_v_reg |-> o_v_reg)
        else $error("skid word held while output register empty");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && c_v_reg && c_it_reg.is_load) |=> !r_v_reg)
        else $error("load word continued past the table stage");

    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (per_reg != '0) && (stp_reg != '0))
        else $error("divisor register is zero");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(w_v_reg[QB-1]) && $stable(c_v_reg)))
        else $error("pipeline stage changed during stall");

endmodule

// ----- verif/periodic_track_interpolator_checker.sv -----
// Scoreboard for periodic_track_interpolator_core: follows the input, result and register channels,
// predicts every query answer and compares it with the result word. Depends on pti_pkg.
`timescale 1ns / 100ps

module periodic_track_interpolator_checker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic                   s_cmd,
    input  logic [pti_pkg::TW-1:0] s_query_time,
    input  logic [5:0]             s_point_index,
    input  logic [pti_pkg::CW-1:0] s_point_x,
    input  logic [pti_pkg::CW-1:0] s_point_y,
    input  logic [pti_pkg::CW-1:0] s_base_x,
    input  logic [pti_pkg::CW-1:0] s_base_y,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [pti_pkg::OW-1:0] m_pos_x,
    input  logic [pti_pkg::OW-1:0] m_pos_y,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [pti_pkg::TW-1:0] cfg_data,
    output int                     errors,
    output int                     pending,
    output int                     answered,
    output int                     loads_seen
);
    import pti_pkg::*;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] y;
    } position_t;

    logic [TW-1:0] period_q, step_q, offset_q;
    logic [63:0]   track_x [64];
    logic [63:0]   track_y [64];
    position_t     expected_pos [$];

    initial begin
        errors = 0;
        pending = 0;
        answered = 0;
        loads_seen = 0;
        for (int i = 0; i < 64; i++) begin
            track_x[i] = '0;
            track_y[i] = '0;
        end
    end

    // Signed difference times rem / step, truncated toward zero, with a full-width product.
    function automatic logic [63:0] scale_diff(input logic [63:0] d, input logic [63:0] rem,
                                               input logic [63:0] stp);
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [63:0]  q;
        mag  = d[63] ? -d : d;
        prod = {64'd0, mag} * {64'd0, rem};
        q    = 64'(prod / {64'd0, stp});
        return d[63] ? -q : q;
    endfunction

    function automatic position_t track_position(input logic [TW-1:0] qt,
                                                 input logic [CW-1:0] bx,
                                                 input logic [CW-1:0] by);
        logic [63:0] per, stp, t, seg, nxt, rem;
        position_t   p;
        per = (period_q == '0) ? 64'd1 : {2'b00, period_q};
        stp = (step_q == '0) ? 64'd1 : {2'b00, step_q};
        t   = ({2'b00, qt} + {2'b00, offset_q}) % per;
        seg = t / stp;
        if (seg > 64'd63) begin
            seg = 64'd63;
        end
        nxt = (seg + 64'd1) % 64'd64;
        rem = t % stp;
        p.x = scale_diff(track_x[nxt[5:0]] - track_x[seg[5:0]], rem, stp)
              + track_x[seg[5:0]] + {bx[CW-1], bx};
        p.y = scale_diff(track_y[nxt[5:0]] - track_y[seg[5:0]], rem, stp)
              + track_y[seg[5:0]] + {by[CW-1], by};
        return p;
    endfunction

    always @(posedge aclk) begin
        position_t want;
        if (!aresetn) begin
            period_q <= TW'(1);
            step_q   <= TW'(1);
            offset_q <= '0;
            expected_pos.delete();
            pending  <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PERIOD:       period_q <= cfg_data;
                    REG_STEP_TIME:    step_q   <= cfg_data;
                    REG_CLOCK_OFFSET: offset_q <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_cmd) begin
                    track_x[s_point_index] = {s_point_x[CW-1], s_point_x};
                    track_y[s_point_index] = {s_point_y[CW-1], s_point_y};
                    loads_seen++;
                end else begin
                    expected_pos.push_back(track_position(s_query_time, s_base_x, s_base_y));
                end
            end
            if (m_valid && m_ready) begin
                if (expected_pos.size() == 0) begin
                    $error("result word with no query outstanding: pos_x %h pos_y %h",
                           m_pos_x, m_pos_y);
                    errors++;
                end else begin
                    want = expected_pos.pop_front();
                    answered++;
                    if (m_pos_x !== want.x) begin
                        $error("pos_x: expected %h, got %h", want.x, m_pos_x);
                        errors++;
                    end
                    if (m_pos_y !== want.y) begin
                        $error("pos_y: expected %h, got %h", want.y, m_pos_y);
                        errors++;
                    end
                end
            end
            pending <= expected_pos.size();
        end
    end

endmodule

// ----- verif/periodic_track_interpolator_core_tb.sv -----
// Top of the periodic_track_interpolator_core testbench: clock, reset, register writes,
// load and query words, result back-pressure and the verdict. Uses the checker and pti_pkg.
`timescale 1ns / 100ps

module periodic_track_interpolator_core_tb;
    import pti_pkg::*;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic          s_cmd = 1'b0;
    logic [TW-1:0] s_query_time = '0;
    logic [5:0]    s_point_index = '0;
    logic [CW-1:0] s_point_x = '0, s_point_y = '0, s_base_x = '0, s_base_y = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [OW-1:0] m_pos_x, m_pos_y;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = REG_PERIOD;
    logic [TW-1:0] cfg_data = '0;

    int errors, pending, answered, loads_seen;
    int  words_sent = 0;
    bit  no_gaps = 1'b0;
    bit  holding = 1'b0;
    bit  hold_done = 1'b0;

    localparam logic [TW-1:0] TMAX = {TW{1'b1}};
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    always #6 aclk = ~aclk;

    periodic_track_interpolator_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_query_time(s_query_time),
        .s_point_index(s_point_index), .s_point_x(s_point_x), .s_point_y(s_point_y),
        .s_base_x(s_base_x), .s_base_y(s_base_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_pos_x(m_pos_x), .m_pos_y(m_pos_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    periodic_track_interpolator_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_query_time(s_query_time),
        .s_point_index(s_point_index), .s_point_x(s_point_x), .s_point_y(s_point_y),
        .s_base_x(s_base_x), .s_base_y(s_base_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_pos_x(m_pos_x), .m_pos_y(m_pos_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .answered(answered), .loads_seen(loads_seen)
    );

    function automatic int gap_len();
        int r;
        if (no_gaps || holding) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return CMAX;
            1:       return CMIN;
            2:       return CW'($signed($urandom_range(0, 2000)) - 1000);
            default: return CW'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [TW-1:0] rand_time();
        return TW'({$urandom, $urandom});
    endfunction

    task automatic send_word(input logic cmd, input logic [TW-1:0] qt, input logic [5:0] idx,
                             input logic [CW-1:0] ax, input logic [CW-1:0] ay,
                             input logic [CW-1:0] bx, input logic [CW-1:0] by);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_query_time  <= qt;
        s_point_index <= idx;
        s_point_x     <= ax;
        s_point_y     <= ay;
        s_base_x      <= bx;
        s_base_y      <= by;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic load_point(input logic [5:0] idx, input logic [CW-1:0] px,
                              input logic [CW-1:0] py);
        send_word(1'b1, rand_time(), idx, px, py, rand_coord(), rand_coord());
    endtask

    task automatic query(input logic [TW-1:0] qt, input logic [CW-1:0] bx,
                         input logic [CW-1:0] by);
        send_word(1'b0, qt, 6'($urandom), rand_coord(), rand_coord(), bx, by);
    endtask

    // Drains every answer plus the tail of any load still in the pipeline.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (220) @(posedge aclk);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back; the caller drops it.
    task automatic write_reg(input cfg_reg_t idx, input logic [TW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_track(input logic [TW-1:0] per, input logic [TW-1:0] stp,
                             input logic [TW-1:0] off);
        settle();
        write_reg(REG_PERIOD, per);
        write_reg(REG_STEP_TIME, stp);
        write_reg(REG_CLOCK_OFFSET, off);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure, plus one long hold while the sender keeps pushing.
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!hold_done && words_sent >= 250) begin
                hold_done = 1'b1;
                holding = 1'b1;
                m_ready <= 1'b0;
                for (int c = 0; c < 700; c++) @(posedge aclk);
                holding = 1'b0;
            end else begin
                m_ready <= no_gaps ? 1'b1 : ($urandom_range(0, 9) < 7);
                @(posedge aclk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [TW-1:0] stp;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every slot is filled before any query so no unwritten entry is ever read.
        no_gaps = 1'b1;
        for (int i = 0; i < 64; i++) begin
            load_point(6'(i), rand_coord(), rand_coord());
        end
        no_gaps = 1'b0;
        // Queries under the reset values: period and step of one.
        query(rand_time(), CMAX, CMIN);
        query(TMAX, CMIN, CMAX);

        set_track(TW'(64000), TW'(1000), '0);
        load_point(6'd0, CMAX, CMIN);
        load_point(6'd63, CMIN, CMAX);
        load_point(6'd1, CMIN, CMIN);
        query(TW'(0), '0, '0);
        query(TW'(999), CMAX, CMAX);
        query(TW'(1000), CMIN, CMIN);
        query(TW'(63500), '0, '0);   // last segment interpolates back toward slot 0
        query(TW'(63999), CMAX, CMIN);
        query(TW'(64000), '0, '0);
        query(TMAX, CMIN, CMAX);

        // Period longer than the table spans, so the segment index overruns and clamps.
        set_track(TW'(100000), TW'(1000), TW'(500));
        query(TW'(70250), '0, '0);
        query(TW'(99999), CMAX, CMAX);

        // Extreme register values, then zero registers that behave as one.
        set_track(TMAX, TMAX, TMAX);
        query(TMAX, '0, '0);
        query(TW'(1), CMIN, CMIN);
        query(TMAX - TW'(1), CMAX, CMIN);
        set_track('0, '0, TMAX);
        query(rand_time(), '0, '0);
        query(TMAX, CMAX, CMAX);
        set_track(TMAX, TW'(1), '0);
        query(TW'(62), '0, '0);
        query(rand_time(), CMIN, CMAX);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       stp = TW'($urandom_range(1, 50));
                3:       stp = TW'({$urandom, $urandom}) >> 7;
                default: stp = TW'($urandom_range(1, 100000));
            endcase
            set_track(stp * TW'(64) + TW'($urandom_range(0, 2)) * stp - TW'($urandom_range(0, 1)),
                      stp, (ph == 4) ? rand_time() : TW'($urandom_range(0, 5000)));
            no_gaps = (ph == 2);
            for (int n = 0; n < 85; n++) begin
                if ($urandom_range(0, 9) < 3) begin
                    load_point(6'($urandom), rand_coord(), rand_coord());
                end else begin
                    query(rand_time(), rand_coord(), rand_coord());
                end
            end
            no_gaps = 1'b0;
        end

        settle();
        $display("Ran %0d words: %0d point loads and %0d checked query answers,", words_sent,
                 loads_seen, answered);
        $display("over reset, directed, extreme and random track settings with back-pressure.");
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
